>>> rtl/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;

  // which diagonal term drives the conversion
  typedef logic [1:0] branch_t;

  localparam branch_t BR_X     = 2'd0;
  localparam branch_t BR_Y     = 2'd1;
  localparam branch_t BR_Z     = 2'd2;
  localparam branch_t BR_TRACE = 2'd3;

  // magnitudes are brought below 2^MAG_LIMIT_BITS before squaring
  localparam int MAG_LIMIT_BITS = 30;

endpackage

>>> rtl/rmq_ifs.sv
// channel interfaces for the matrix input and the quaternion result
`timescale 1ns / 1ps
interface rmq_mat_if #(parameter int WORD_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] m00, m01, m02;
  logic signed [WORD_WIDTH-1:0] m10, m11, m12;
  logic signed [WORD_WIDTH-1:0] m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_quat_if #(parameter int WORD_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0]                   branch_used;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_used,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, branch_used,
                  output ready);
endinterface

>>> rtl/rmq_front.sv
// front end: branch choice, scaled components, sign and magnitude split
`timescale 1ns / 1ps
module rmq_front #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 14,
  parameter int MAG_W      = 17,
  parameter int SIDE_W     = 74
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [WORD_WIDTH-1:0] mat [9],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SIDE_W-1:0]            out_side
);
  import rmq_pkg::*;

  localparam int VW    = WORD_WIDTH + 2;
  localparam int MW    = WORD_WIDTH + 1;
  localparam int SHMAX = MW - MAG_W;
  localparam logic signed [VW-1:0] ONE_V = VW'(1) <<< FRAC_BITS;

  logic signed [VW-1:0] a [9];
  logic signed [VW-1:0] v [4];
  logic [MW-1:0]        mag [4];
  logic [MW-1:0]        biggest;
  logic [MAG_W-1:0]     mag_sh [4];
  logic [3:0]           neg;
  branch_t              branch;
  logic [SIDE_W-1:0]    side_nxt;
  logic                 valid_r;
  logic [SIDE_W-1:0]    side_r;

  // sign extension of the entries
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a[i] = VW'(mat[i]);
    end
  end

  // branch order: x, y, z, then trace
  always_comb begin
    if (a[0] >= a[4] + a[8]) begin
      branch = BR_X;
      v[1] = ONE_V + a[0] - a[4] - a[8];
      v[0] = a[7] - a[5];
      v[2] = a[1] + a[3];
      v[3] = a[2] + a[6];
    end else if (a[4] >= a[0] + a[8]) begin
      branch = BR_Y;
      v[2] = ONE_V - a[0] + a[4] - a[8];
      v[0] = a[2] - a[6];
      v[1] = a[1] + a[3];
      v[3] = a[5] + a[7];
    end else if (a[8] >= a[0] + a[4]) begin
      branch = BR_Z;
      v[3] = ONE_V - a[0] - a[4] + a[8];
      v[0] = a[3] - a[1];
      v[1] = a[2] + a[6];
      v[2] = a[5] + a[7];
    end else begin
      branch = BR_TRACE;
      v[0] = ONE_V + a[0] + a[4] + a[8];
      v[1] = a[7] - a[5];
      v[2] = a[2] - a[6];
      v[3] = a[3] - a[1];
    end
  end

  // sign and magnitude, plus the largest magnitude
  always_comb begin
    biggest = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i][VW-1];
      mag[i] = neg[i] ? MW'(-v[i]) : MW'(v[i]);
      if (mag[i] > biggest) begin
        biggest = mag[i];
      end
    end
  end

  // smallest right shift that keeps the largest magnitude in range
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_sh[i] = MAG_W'(mag[i]);
    end
    for (int s = SHMAX; s >= 0; s--) begin
      if (((biggest >> s) >> MAG_LIMIT_BITS) == '0) begin
        for (int i = 0; i < 4; i++) begin
          mag_sh[i] = MAG_W'(mag[i] >> s);
        end
      end
    end
  end

  always_comb begin
    side_nxt = {branch, neg, mag_sh[3], mag_sh[2], mag_sh[1], mag_sh[0]};
  end

  // output register toward the queue
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;

endmodule

>>> rtl/rmq_fifo.sv
// two entry queue between front and back
`timescale 1ns / 1ps
module rmq_fifo #(
  parameter int DATA_W = 74
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);
  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;
  logic              push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

  ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  ap_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1 && pop && !push) |=> (count_r == 2'd0))
    else $error("queue count lost an item");

endmodule

>>> rtl/rmq_back.sv
// back end: sum of squares, pipelined root, pipelined division, saturation
`timescale 1ns / 1ps
module rmq_back #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 14,
  parameter int MAG_W      = 17,
  parameter int SIDE_W     = 74
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] quat [4],
  output logic [1:0]                   branch_used
);
  import rmq_pkg::*;

  localparam int SW = 2 * MAG_W + 2;
  localparam int RW = MAG_W + 1;
  localparam int DW = MAG_W + FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int ND = FRAC_BITS + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic adv;

  // square stage
  logic              va_r;
  logic [SIDE_W-1:0] sa_r;
  logic [2*MAG_W-1:0] sq_r [4];
  // pair sum stage
  logic              vb_r;
  logic [SIDE_W-1:0] sb_r;
  logic [2*MAG_W:0]  p01_r, p23_r;
  // root stages
  logic              vs_r [RW+1];
  logic [SIDE_W-1:0] ss_r [RW+1];
  logic [SW-1:0]     sum_r [RW+1];
  logic [RW-1:0]     rt_r [RW+1];
  logic [RW+1:0]     rm_r [RW+1];
  // divider stages
  logic              vd_r [ND+1];
  logic [SIDE_W-1:0] sd_r [ND+1];
  logic [DW-1:0]     dv_r [ND+1];
  logic [DW-1:0]     drem_r [ND+1][4];
  logic [QW-1:0]     dq_r [ND+1][4];
  // result register
  logic                         out_valid_r;
  logic signed [WORD_WIDTH-1:0] quat_r [4];
  logic [1:0]                   branch_r;

  logic [RW-1:0] root_fix;
  logic [QW-1:0] q_sat [4];

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // squares of the four magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r <= in_side;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= in_side[i*MAG_W +: MAG_W] * in_side[i*MAG_W +: MAG_W];
      end
    end
  end

  // pairwise sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r  <= sa_r;
      p01_r <= (2*MAG_W+1)'(sq_r[0]) + (2*MAG_W+1)'(sq_r[1]);
      p23_r <= (2*MAG_W+1)'(sq_r[2]) + (2*MAG_W+1)'(sq_r[3]);
    end
  end

  // full sum enters the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (adv) begin
      vs_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r[0]  <= sb_r;
      sum_r[0] <= SW'(p01_r) + SW'(p23_r);
      rt_r[0]  <= '0;
      rm_r[0]  <= '0;
    end
  end

  // one root bit per stage, two sum bits consumed each
  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RW+3:0] remx, trial;
    logic          ge;

    always_comb begin
      remx  = {rm_r[k], sum_r[k][SW-1-2*k -: 2]};
      trial = (RW+4)'({rt_r[k], 2'b01});
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else if (adv) begin
        vs_r[k+1] <= vs_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss_r[k+1]  <= ss_r[k];
        sum_r[k+1] <= sum_r[k];
        rm_r[k+1]  <= ge ? (RW+2)'(remx - trial) : (RW+2)'(remx);
        rt_r[k+1]  <= {rt_r[k][RW-2:0], ge};
      end
    end
  end

  // rounded numerators and divisor
  assign root_fix = (rt_r[RW] == '0) ? RW'(1) : rt_r[RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= vs_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= ss_r[RW];
      dv_r[0] <= DW'(root_fix);
      for (int i = 0; i < 4; i++) begin
        drem_r[0][i] <= (DW'(ss_r[RW][i*MAG_W +: MAG_W]) << FRAC_BITS)
                        + DW'(root_fix >> 1);
        dq_r[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage for all four lanes
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [DW-1:0] trial;
    logic [3:0]    ge;

    always_comb begin
      trial = dv_r[j] << (FRAC_BITS - j);
      for (int i = 0; i < 4; i++) begin
        ge[i] = (drem_r[j][i] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (adv) begin
        vd_r[j+1] <= vd_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[j+1] <= sd_r[j];
        dv_r[j+1] <= dv_r[j];
        for (int i = 0; i < 4; i++) begin
          drem_r[j+1][i] <= ge[i] ? drem_r[j][i] - trial : drem_r[j][i];
          dq_r[j+1][i]   <= {dq_r[j][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // limit to one and restore the sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_sat[i] = (dq_r[ND][i] > ONE_Q) ? ONE_Q : dq_r[ND][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        quat_r[i] <= sd_r[ND][4*MAG_W + i]
                     ? -$signed(WORD_WIDTH'(q_sat[i]))
                     :  $signed(WORD_WIDTH'(q_sat[i]));
      end
      branch_r <= sd_r[ND][4*MAG_W+4 +: 2];
    end
  end

  assign out_valid   = out_valid_r;
  assign quat        = quat_r;
  assign branch_used = branch_r;

  ap_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r[RW] |-> (rt_r[RW] != '0)) else $error("root of a live item is zero");
  ap_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[ND] |-> (dq_r[ND][0] <= ONE_Q && dq_r[ND][1] <= ONE_Q &&
                  dq_r[ND][2] <= ONE_Q && dq_r[ND][3] <= ONE_Q))
    else $error("quotient above one");
  ap_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[ND] |-> (drem_r[ND][0] < dv_r[ND] && drem_r[ND][3] < dv_r[ND]))
    else $error("division remainder not reduced");
  ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(branch_r)))
    else $error("result changed under stall");

endmodule

>>> rtl/rotation_matrix_to_quaternion_top.sv
// top level: rotation matrix to unit quaternion converter
//
// in_ch carries one 3x3 matrix per item (signed, FRAC_BITS fraction bits),
// out_ch one normalized quaternion per item plus the branch code that was
// used. Both channels use valid/ready; an item moves when both are high.
// Throughput is one item per clock while out_ready stays high. From input
// acceptance to the result showing on out_ch an item passes through
// one front register, one queue slot, squares, two adder
// stages, one root bit per stage over WORD_WIDTH + 2 stages, a setup stage,
// FRAC_BITS + 1 divider stages and the result register.
// The front end and the back pipeline are split by a two-item queue, so the
// front keeps accepting while the back stalls, until the queue fills.
// When out_ready is low the whole back pipeline holds its items and the
// result stays on out_ch; nothing is dropped.
// Reset (rst_n low, synchronous) empties every stage and the queue;
// no state is kept between items.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_mat_if.sink   in_ch,
  rmq_quat_if.source out_ch
);
  import rmq_pkg::*;

  localparam int MW     = WORD_WIDTH + 1;
  localparam int MAG_W  = (MW > MAG_LIMIT_BITS) ? MAG_LIMIT_BITS : MW;
  localparam int SIDE_W = 4 * MAG_W + 6;

  logic signed [WORD_WIDTH-1:0] mat [9];
  logic                         fr_valid, fr_ready;
  logic [SIDE_W-1:0]            fr_side;
  logic                         q_valid, q_ready;
  logic [SIDE_W-1:0]            q_side;
  logic signed [WORD_WIDTH-1:0] quat [4];

  assign mat[0] = in_ch.m00;
  assign mat[1] = in_ch.m01;
  assign mat[2] = in_ch.m02;
  assign mat[3] = in_ch.m10;
  assign mat[4] = in_ch.m11;
  assign mat[5] = in_ch.m12;
  assign mat[6] = in_ch.m20;
  assign mat[7] = in_ch.m21;
  assign mat[8] = in_ch.m22;

  // classification and component setup
  rmq_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAG_W      (MAG_W),
    .SIDE_W     (SIDE_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .mat       (mat),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_side  (fr_side)
  );

  // decoupling queue
  rmq_fifo #(
    .DATA_W (SIDE_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_side),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_side)
  );

  // normalization pipeline
  rmq_back #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAG_W      (MAG_W),
    .SIDE_W     (SIDE_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_side     (q_side),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .quat        (quat),
    .branch_used (out_ch.branch_used)
  );

  assign out_ch.quat_w = quat[0];
  assign out_ch.quat_x = quat[1];
  assign out_ch.quat_y = quat[2];
  assign out_ch.quat_z = quat[3];

endmodule

>>> sim/rmq_checker.sv
// checker: watches both channels, predicts quaternions and compares
`timescale 1ns / 1ps
module rmq_checker (
  input  logic     clk,
  input  logic     rst_n,
  rmq_mat_if       in_ch,
  rmq_quat_if      out_ch,
  output int       fail_count,
  output int       pending
);
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam longint ONE = 64'sd1 << FRAC;

  typedef struct packed {
    logic [15:0] w, x, y, z;
    branch_t     br;
  } quat_t;

  quat_t quat_queue[$];

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // predicted quaternion for one matrix
  function automatic quat_t matrix_to_quat(longint a00, longint a01, longint a02,
                                           longint a10, longint a11, longint a12,
                                           longint a20, longint a21, longint a22);
    longint v[4];
    longint unsigned mag[4], biggest, total, r, q;
    logic [15:0] o[4];
    quat_t res;
    int sh;
    biggest = 0;
    total = 0;
    sh = 0;
    if (a00 >= a11 + a22) begin
      res.br = BR_X;
      v[1] = ONE + a00 - a11 - a22;
      v[0] = a21 - a12; v[2] = a01 + a10; v[3] = a02 + a20;
    end else if (a11 >= a00 + a22) begin
      res.br = BR_Y;
      v[2] = ONE - a00 + a11 - a22;
      v[0] = a02 - a20; v[1] = a01 + a10; v[3] = a12 + a21;
    end else if (a22 >= a00 + a11) begin
      res.br = BR_Z;
      v[3] = ONE - a00 - a11 + a22;
      v[0] = a10 - a01; v[1] = a02 + a20; v[2] = a12 + a21;
    end else begin
      res.br = BR_TRACE;
      v[0] = ONE + a00 + a11 + a22;
      v[1] = a21 - a12; v[2] = a02 - a20; v[3] = a10 - a01;
    end
    for (int i = 0; i < 4; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > biggest) biggest = mag[i];
    end
    while ((biggest >> sh) >= (64'd1 << MAG_LIMIT_BITS)) sh++;
    for (int i = 0; i < 4; i++) begin
      mag[i] >>= sh;
      total += mag[i] * mag[i];
    end
    r = isqrt(total);
    if (r == 0) r = 1;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << FRAC) + (r >> 1)) / r;
      if (q > ONE) q = ONE;
      o[i] = (v[i] < 0) ? 16'(-q) : 16'(q);
    end
    res.w = o[0]; res.x = o[1]; res.y = o[2]; res.z = o[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    quat_t want;
    if (rst_n) begin
      // expectation for every accepted matrix
      if (in_ch.valid && in_ch.ready)
        quat_queue.push_back(matrix_to_quat(in_ch.m00, in_ch.m01, in_ch.m02,
                                            in_ch.m10, in_ch.m11, in_ch.m12,
                                            in_ch.m20, in_ch.m21, in_ch.m22));
      // compare accepted quaternion with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (quat_queue.size() == 0) begin
          $display("unexpected quaternion item");
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          if (out_ch.quat_w !== want.w) report_mismatch("quat_w", out_ch.quat_w, want.w);
          if (out_ch.quat_x !== want.x) report_mismatch("quat_x", out_ch.quat_x, want.x);
          if (out_ch.quat_y !== want.y) report_mismatch("quat_y", out_ch.quat_y, want.y);
          if (out_ch.quat_z !== want.z) report_mismatch("quat_z", out_ch.quat_z, want.z);
          if (out_ch.branch_used !== want.br)
            report_mismatch("branch_used", 16'(out_ch.branch_used), 16'(want.br));
        end
      end
    end
    // items still awaiting their result
    pending = quat_queue.size();
  end
endmodule

>>> sim/rotation_matrix_to_quaternion_top_tb.sv
// testbench top: matrix stimulus, result stalls and the verdict
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top_tb;
  localparam int LATENCY = 40;
  localparam int N_RANDOM = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  bit   quiet = 1'b0;      // no idling in the last part
  bit   long_hold = 1'b0;  // receiver holds off

  rmq_mat_if  in_ch();
  rmq_quat_if out_ch();

  rotation_matrix_to_quaternion_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  rmq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
     in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // offer one matrix and hold until accepted; valid stays up for the next one
  task automatic send_matrix(logic [15:0] m [9]);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.m00 <= m[0]; in_ch.m01 <= m[1]; in_ch.m02 <= m[2];
    in_ch.m10 <= m[3]; in_ch.m11 <= m[4]; in_ch.m12 <= m[5];
    in_ch.m20 <= m[6]; in_ch.m21 <= m[7]; in_ch.m22 <= m[8];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // near-rotation: dominant diagonal picked by kind, small random noise
  function automatic void make_rotation(output logic [15:0] m [9], input int kind);
    for (int i = 0; i < 9; i++) m[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
    for (int i = 0; i < 3; i++) m[i*4] = 16'($signed($urandom_range(0, 6000)) - 3000);
    if (kind < 3) m[kind*4] = 16'($urandom_range(10000, 16384));
    else for (int i = 0; i < 3; i++) m[i*4] = 16'($urandom_range(6000, 16384));
  endfunction

  initial begin
    logic [15:0] m [9];
    logic [15:0] ext [4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, each axis flip, extremes
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) m[i] = ext[k];
      send_matrix(m);
    end
    m = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
          16'h7fff, 16'h8000, 16'h8000}; send_matrix(m);
    m = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h7fff}; send_matrix(m);
    m = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
          16'h7fff, 16'h7fff, 16'h8000}; send_matrix(m);
    // ties on the branch tests
    m = '{8192, 100, -100, 200, 4096, 300, -300, 50, 4096}; send_matrix(m);
    m = '{4096, 100, -100, 200, 8192, 300, -300, 50, 4096}; send_matrix(m);
    m = '{4096, 100, -100, 200, 4096, 300, -300, 50, 8192}; send_matrix(m);

    // random part, long receiver hold-off partway through
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) long_hold = 1'b1;
      if (n == 800) begin
        // sender pauses until every result is back
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 9; i++) m[i] = 16'($urandom());
      end else begin
        make_rotation(m, $urandom_range(0, 3));
      end
      send_matrix(m);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
